FILE: hw/rtl/sgpf_pkg.sv
// ============================================================================
// sgpf_pkg: shared types and constants of the softened gravity pair force unit
// Field widths, pipeline depths and the queue entry that the front hands over.
// ============================================================================
package sgpf_pkg;

  localparam int COORD_W   = 32;
  localparam int MASS_W    = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam int MAG_W     = 33;              // |other - self| needs one more bit
  localparam int SQ_W      = 66;              // dx*dx + dy*dy
  localparam int DEN_W     = 67;              // s + softening, shifted
  localparam int PROD_W    = 64;              // G * self_mass
  localparam int NUM_W     = 96;              // G * self_mass * other_mass
  localparam int FQ_QW     = 78;              // quotient bits below the clamp
  localparam int FQ_W      = FQ_QW + 1;       // scalar force, clamped at 2^78
  localparam int ISQ_IN_W  = 98;              // s with 32 extra fraction bits
  localparam int ROOT_W    = ISQ_IN_W / 2;    // distance, 49 bits
  localparam int U_SHIFT   = 46;
  localparam int UNUM_W    = MAG_W + U_SHIFT; // unit numerator
  localparam int U_QW      = 31;
  localparam int UNIT_BITS = 30;
  localparam int CHUNK_W   = 27;
  localparam int PP_W      = CHUNK_W + U_QW;  // one partial product
  localparam int ACC_W     = 112;
  localparam int PX_W      = ACC_W - UNIT_BITS;
  localparam int FORCE_W   = 48;

  localparam int FQ_LAT    = FQ_QW + 1;
  localparam int SQ_LAT    = ROOT_W + 1;
  localparam int U_LAT     = U_QW + 1;
  localparam int ALIGN     = SQ_LAT + U_LAT;
  localparam int FQ_PAD    = ALIGN - FQ_LAT;
  localparam int PIPE_N    = 3 + ALIGN + 4;

  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;
  localparam int QCNT_W    = 3;

  localparam logic [CFG_W-1:0]   GRAVITY_RESET = 32'd65536;
  localparam logic [CFG_W-1:0]   SOFTEN_RESET  = 32'd59;
  localparam logic [FORCE_W-1:0] FORCE_POS_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [FORCE_W-1:0] FORCE_NEG_MAG = 48'h8000_0000_0000;
  localparam logic [U_QW-1:0]    UNIT_ONE      = 31'h4000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRAVITY = 1'b0,
    REG_SOFTEN  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [MAG_W-1:0]  adx;
    logic [MAG_W-1:0]  ady;
    logic              negx;
    logic              negy;
    logic              coinc;
    logic [MASS_W-1:0] m1;
    logic [MASS_W-1:0] m2;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

FILE: hw/rtl/sgpf_delay.sv
// ============================================================================
// sgpf_delay: enabled delay line
// Holds side data in step with the long arithmetic pipelines.
// ============================================================================
module sgpf_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign q = line[DEPTH-1];

endmodule

FILE: hw/rtl/sgpf_div_pipe.sv
// ============================================================================
// sgpf_div_pipe: pipelined restoring divider
// One quotient bit per stage; flags quotients that need more than Q_W bits.
// ============================================================================
module sgpf_div_pipe #(
  parameter int NUM_W = 96,
  parameter int DEN_W = 67,
  parameter int Q_W   = 78
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo,
  output logic             ovf
);

  logic [DEN_W-1:0] rem [Q_W+1];
  logic [DEN_W-1:0] dv  [Q_W+1];
  logic [Q_W-1:0]   lo  [Q_W+1];
  logic [Q_W-1:0]   qb  [Q_W+1];
  logic             ov  [Q_W+1];

  // high part must already sit below the divisor, else the quotient overflows
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= DEN_W'(num[NUM_W-1:Q_W]);
      dv[0]  <= den;
      lo[0]  <= num[Q_W-1:0];
      qb[0]  <= '0;
      ov[0]  <= ((DEN_W+1)'(num[NUM_W-1:Q_W]) >= (DEN_W+1)'(den));
    end
  end

  for (genvar g = 0; g < Q_W; g++) begin : g_stage
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           take;

    assign trial = {rem[g], lo[g][Q_W-1]};
    assign diff  = trial - {1'b0, dv[g]};
    assign take  = (trial >= {1'b0, dv[g]});

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g+1] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        dv[g+1]  <= dv[g];
        lo[g+1]  <= lo[g] << 1;
        qb[g+1]  <= {qb[g][Q_W-2:0], take};
        ov[g+1]  <= ov[g];
      end
    end
  end

  assign quo = qb[Q_W];
  assign ovf = ov[Q_W];

endmodule

FILE: hw/rtl/sgpf_isqrt_pipe.sv
// ============================================================================
// sgpf_isqrt_pipe: pipelined integer square root
// Digit-by-digit floor square root, one root bit per stage.
// ============================================================================
module sgpf_isqrt_pipe #(
  parameter int IN_W = 98
) (
  input  logic                clk,
  input  logic                en,
  input  logic [IN_W-1:0]     n,
  output logic [IN_W/2-1:0]   root
);

  localparam int R_W = IN_W / 2;

  logic [IN_W-1:0] nb [R_W+1];
  logic [R_W:0]    r  [R_W+1];
  logic [R_W-1:0]  q  [R_W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      nb[0] <= n;
      r[0]  <= '0;
      q[0]  <= '0;
    end
  end

  for (genvar g = 0; g < R_W; g++) begin : g_stage
    logic [R_W+2:0] r2;
    logic [R_W+2:0] t;
    logic [R_W+2:0] diff;
    logic           take;

    assign r2   = {r[g], nb[g][IN_W-1 -: 2]};
    assign t    = {1'b0, q[g], 2'b01};
    assign diff = r2 - t;
    assign take = (r2 >= t);

    always_ff @(posedge clk) begin
      if (en) begin
        nb[g+1] <= nb[g] << 2;
        r[g+1]  <= take ? diff[R_W:0] : r2[R_W:0];
        q[g+1]  <= {q[g][R_W-2:0], take};
      end
    end
  end

  assign root = q[R_W];

endmodule

FILE: hw/rtl/sgpf_queue.sv
// ============================================================================
// sgpf_queue: short queue between front and back
// Lets the front keep taking items while the back holds on a stalled output.
// ============================================================================
module sgpf_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sgpf_pkg::item_t wdata,
  input  logic            pop,
  output sgpf_pkg::item_t rdata,
  output sgpf_pkg::qstat_t stat
);

  sgpf_pkg::item_t                   mem [sgpf_pkg::QDEPTH];
  logic [sgpf_pkg::QPTR_W-1:0]       wptr;
  logic [sgpf_pkg::QPTR_W-1:0]       rptr;
  logic [sgpf_pkg::QCNT_W-1:0]       count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign rdata      = mem[rptr];
  assign stat.full  = (count == sgpf_pkg::QCNT_W'(sgpf_pkg::QDEPTH));
  assign stat.empty = (count == '0);

endmodule

FILE: hw/rtl/sgpf_front.sv
// ============================================================================
// sgpf_front: input stage
// Takes a body pair, forms the separation magnitudes and signs, flags coincidence.
// ============================================================================
module sgpf_front (
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [sgpf_pkg::COORD_W-1:0] self_x,
  input  logic signed [sgpf_pkg::COORD_W-1:0] self_y,
  input  logic        [sgpf_pkg::MASS_W-1:0]  self_mass,
  input  logic signed [sgpf_pkg::COORD_W-1:0] other_x,
  input  logic signed [sgpf_pkg::COORD_W-1:0] other_y,
  input  logic        [sgpf_pkg::MASS_W-1:0]  other_mass,
  input  sgpf_pkg::qstat_t                    qstat,
  output logic                                push,
  output sgpf_pkg::item_t                     item
);

  logic signed [sgpf_pkg::MAG_W-1:0] dx;
  logic signed [sgpf_pkg::MAG_W-1:0] dy;

  assign dx = sgpf_pkg::MAG_W'(other_x) - sgpf_pkg::MAG_W'(self_x);
  assign dy = sgpf_pkg::MAG_W'(other_y) - sgpf_pkg::MAG_W'(self_y);

  always_comb begin
    item.negx  = dx[sgpf_pkg::MAG_W-1];
    item.negy  = dy[sgpf_pkg::MAG_W-1];
    item.adx   = item.negx ? -dx : dx;
    item.ady   = item.negy ? -dy : dy;
    item.coinc = (dx == '0) && (dy == '0);
    item.m1    = self_mass;
    item.m2    = other_mass;
  end

  assign in_stall = qstat.full;
  assign push     = in_valid && !qstat.full;

endmodule

FILE: hw/rtl/sgpf_back.sv
// ============================================================================
// sgpf_back: force datapath
// Squares, products, scalar force and unit vector dividers, scaling, clamp.
// ============================================================================
module sgpf_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [sgpf_pkg::CFG_W-1:0]          gravity,
  input  logic [sgpf_pkg::CFG_W-1:0]          soften,
  input  sgpf_pkg::qstat_t                    qstat,
  input  sgpf_pkg::item_t                     head,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [sgpf_pkg::FORCE_W-1:0] force_x,
  output logic signed [sgpf_pkg::FORCE_W-1:0] force_y,
  output logic                                coincident,
  output logic                                saturated
);

  localparam int MW = sgpf_pkg::MAG_W;

  logic                        adv;
  logic [sgpf_pkg::PIPE_N-1:0] vpipe;

  // every stage moves together; the output register is the last one
  assign adv = !out_valid || !out_stall;
  assign pop = adv && !qstat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (adv) begin
      vpipe <= {vpipe[sgpf_pkg::PIPE_N-2:0], !qstat.empty};
    end
  end

  assign out_valid = vpipe[sgpf_pkg::PIPE_N-1];

  // B1: squares and G * self_mass
  logic [sgpf_pkg::SQ_W-1:0]   b1_sqx, b1_sqy;
  logic [sgpf_pkg::PROD_W-1:0] b1_gm1;
  logic [sgpf_pkg::MASS_W-1:0] b1_m2;
  logic [MW-1:0]               b1_adx, b1_ady;
  logic [2:0]                  b1_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_sqx  <= head.adx * head.adx;
      b1_sqy  <= head.ady * head.ady;
      b1_gm1  <= gravity * head.m1;
      b1_m2   <= head.m2;
      b1_adx  <= head.adx;
      b1_ady  <= head.ady;
      b1_side <= {head.negx, head.negy, head.coinc};
    end
  end

  // B2: sum of squares, partial products of the mass term
  logic [sgpf_pkg::SQ_W-1:0]   b2_s;
  logic [sgpf_pkg::PROD_W-1:0] b2_plo, b2_phi;
  logic [MW-1:0]               b2_adx, b2_ady;
  logic [2:0]                  b2_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      b2_s    <= b1_sqx + b1_sqy;
      b2_plo  <= b1_gm1[31:0] * b1_m2;
      b2_phi  <= b1_gm1[63:32] * b1_m2;
      b2_adx  <= b1_adx;
      b2_ady  <= b1_ady;
      b2_side <= b1_side;
    end
  end

  // B3: numerator and softened denominator
  logic [sgpf_pkg::NUM_W-1:0] b3_num;
  logic [sgpf_pkg::DEN_W-1:0] b3_den;
  logic [sgpf_pkg::SQ_W-1:0]  b3_s;
  logic [MW-1:0]              b3_adx, b3_ady;
  logic [2:0]                 b3_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      b3_num  <= sgpf_pkg::NUM_W'(b2_plo) + {b2_phi, 32'd0};
      b3_den  <= sgpf_pkg::DEN_W'(b2_s)
                 + (sgpf_pkg::DEN_W'(soften) << FRAC_BITS);
      b3_s    <= b2_s;
      b3_adx  <= b2_adx;
      b3_ady  <= b2_ady;
      b3_side <= b2_side;
    end
  end

  // scalar force
  logic [sgpf_pkg::FQ_QW-1:0] fq_q;
  logic                       fq_ovf;
  logic [sgpf_pkg::FQ_W-1:0]  fq_val, fq_al;

  sgpf_div_pipe #(
    .NUM_W(sgpf_pkg::NUM_W), .DEN_W(sgpf_pkg::DEN_W), .Q_W(sgpf_pkg::FQ_QW)
  ) u_fq_div (
    .clk(clk), .en(adv), .num(b3_num), .den(b3_den), .quo(fq_q), .ovf(fq_ovf)
  );

  assign fq_val = fq_ovf ? {1'b1, {sgpf_pkg::FQ_QW{1'b0}}} : {1'b0, fq_q};

  sgpf_delay #(.W(sgpf_pkg::FQ_W), .DEPTH(sgpf_pkg::FQ_PAD)) u_fq_dly (
    .clk(clk), .en(adv), .d(fq_val), .q(fq_al)
  );

  // distance and unit vector
  logic [sgpf_pkg::ROOT_W-1:0] dh;
  logic [2*MW-1:0]             mag_al;

  sgpf_isqrt_pipe #(.IN_W(sgpf_pkg::ISQ_IN_W)) u_isqrt (
    .clk(clk), .en(adv), .n({b3_s, 32'd0}), .root(dh)
  );

  sgpf_delay #(.W(2*MW), .DEPTH(sgpf_pkg::SQ_LAT)) u_mag_dly (
    .clk(clk), .en(adv), .d({b3_adx, b3_ady}), .q(mag_al)
  );

  logic [sgpf_pkg::U_QW-1:0] uqx, uqy, ux, uy;
  logic                      uox, uoy;

  sgpf_div_pipe #(
    .NUM_W(sgpf_pkg::UNUM_W), .DEN_W(sgpf_pkg::ROOT_W), .Q_W(sgpf_pkg::U_QW)
  ) u_ux_div (
    .clk(clk), .en(adv), .num({mag_al[2*MW-1:MW], sgpf_pkg::U_SHIFT'(0)}),
    .den(dh), .quo(uqx), .ovf(uox)
  );

  sgpf_div_pipe #(
    .NUM_W(sgpf_pkg::UNUM_W), .DEN_W(sgpf_pkg::ROOT_W), .Q_W(sgpf_pkg::U_QW)
  ) u_uy_div (
    .clk(clk), .en(adv), .num({mag_al[MW-1:0], sgpf_pkg::U_SHIFT'(0)}),
    .den(dh), .quo(uqy), .ovf(uoy)
  );

  // clamp each unit component at one
  assign ux = (uox || uqx > sgpf_pkg::UNIT_ONE) ? sgpf_pkg::UNIT_ONE : uqx;
  assign uy = (uoy || uqy > sgpf_pkg::UNIT_ONE) ? sgpf_pkg::UNIT_ONE : uqy;

  logic [2:0] side_al;

  sgpf_delay #(.W(3), .DEPTH(sgpf_pkg::ALIGN)) u_side_dly (
    .clk(clk), .en(adv), .d(b3_side), .q(side_al)
  );

  // M1: partial products of force and unit components
  logic [3*sgpf_pkg::CHUNK_W-1:0] fq_ext;
  logic [sgpf_pkg::PP_W-1:0]      m1_px [3];
  logic [sgpf_pkg::PP_W-1:0]      m1_py [3];
  logic [2:0]                     m1_side;

  assign fq_ext = (3*sgpf_pkg::CHUNK_W)'(fq_al);

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        m1_px[i] <= fq_ext[i*sgpf_pkg::CHUNK_W +: sgpf_pkg::CHUNK_W] * ux;
        m1_py[i] <= fq_ext[i*sgpf_pkg::CHUNK_W +: sgpf_pkg::CHUNK_W] * uy;
      end
      m1_side <= side_al;
    end
  end

  // M2, M3: accumulate partial products
  logic [sgpf_pkg::ACC_W-1:0] m2_ax, m2_ay, m3_ax, m3_ay;
  logic [sgpf_pkg::PP_W-1:0]  m2_hx, m2_hy;
  logic [2:0]                 m2_side, m3_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_ax   <= sgpf_pkg::ACC_W'(m1_px[0])
                 + (sgpf_pkg::ACC_W'(m1_px[1]) << sgpf_pkg::CHUNK_W);
      m2_ay   <= sgpf_pkg::ACC_W'(m1_py[0])
                 + (sgpf_pkg::ACC_W'(m1_py[1]) << sgpf_pkg::CHUNK_W);
      m2_hx   <= m1_px[2];
      m2_hy   <= m1_py[2];
      m2_side <= m1_side;
      m3_ax   <= m2_ax + (sgpf_pkg::ACC_W'(m2_hx) << (2*sgpf_pkg::CHUNK_W));
      m3_ay   <= m2_ay + (sgpf_pkg::ACC_W'(m2_hy) << (2*sgpf_pkg::CHUNK_W));
      m3_side <= m2_side;
    end
  end

  // clamp a scaled magnitude and apply its sign; top bit reports a clamp
  function automatic logic [sgpf_pkg::FORCE_W:0] clamp(
    input logic [sgpf_pkg::PX_W-1:0] p,
    input logic                      neg
  );
    logic [sgpf_pkg::PX_W-1:0]    lim;
    logic [sgpf_pkg::FORCE_W-1:0] m;
    logic                         over;
    lim  = neg ? sgpf_pkg::PX_W'(sgpf_pkg::FORCE_NEG_MAG)
               : sgpf_pkg::PX_W'(sgpf_pkg::FORCE_POS_MAX);
    over = (p > lim);
    m    = over ? lim[sgpf_pkg::FORCE_W-1:0] : p[sgpf_pkg::FORCE_W-1:0];
    return {over, neg ? -m : m};
  endfunction

  logic [sgpf_pkg::FORCE_W:0] cx, cy;

  assign cx = clamp(m3_ax[sgpf_pkg::ACC_W-1:sgpf_pkg::UNIT_BITS], m3_side[2]);
  assign cy = clamp(m3_ay[sgpf_pkg::ACC_W-1:sgpf_pkg::UNIT_BITS], m3_side[1]);

  // M4: output register; coincident bodies give no force
  always_ff @(posedge clk) begin
    if (adv) begin
      if (m3_side[0]) begin
        force_x    <= '0;
        force_y    <= '0;
        coincident <= 1'b1;
        saturated  <= 1'b0;
      end else begin
        force_x    <= cx[sgpf_pkg::FORCE_W-1:0];
        force_y    <= cy[sgpf_pkg::FORCE_W-1:0];
        coincident <= 1'b0;
        saturated  <= cx[sgpf_pkg::FORCE_W] || cy[sgpf_pkg::FORCE_W];
      end
    end
  end

endmodule

FILE: hw/rtl/softened_gravity_pair_force_unit.sv
// ============================================================================
// softened_gravity_pair_force_unit: 2D softened gravity pair force
// Streams body pairs and returns the saturated Q32.16 force on the first body.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall): one body pair per transfer, positions
//   signed Q16.16 and masses unsigned Q16.16. The block raises in_stall only
//   when its four-entry input queue is full.
//   Output channel (out_valid / out_stall): one result per pair, in order:
//   force_x, force_y (signed Q32.16, clamped), coincident, saturated.
//   Configuration channel (cfg_valid / cfg_ready): cfg_ready is always high;
//   index 0 writes G, index 1 writes softening squared. Write only while idle.
// Timing:
//   One transfer per cycle sustained while the output is not stalled. The
//   depth of the back pipeline is set by the distance square root (50 stages)
//   feeding the unit vector dividers (32 stages), plus the product,
//   denominator and scaling stages.
// Reset:
//   rst clears the queue and the pipeline valid bits, and loads G = 1.0 and
//   softening squared = 59. While a result waits under out_stall the whole
//   back pipeline holds; the queue keeps taking transfers until it fills.
// ============================================================================
module softened_gravity_pair_force_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sgpf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sgpf_pkg::CFG_W-1:0]          cfg_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [sgpf_pkg::COORD_W-1:0] self_x,
  input  logic signed [sgpf_pkg::COORD_W-1:0] self_y,
  input  logic        [sgpf_pkg::MASS_W-1:0]  self_mass,
  input  logic signed [sgpf_pkg::COORD_W-1:0] other_x,
  input  logic signed [sgpf_pkg::COORD_W-1:0] other_y,
  input  logic        [sgpf_pkg::MASS_W-1:0]  other_mass,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [sgpf_pkg::FORCE_W-1:0] force_x,
  output logic signed [sgpf_pkg::FORCE_W-1:0] force_y,
  output logic                                coincident,
  output logic                                saturated
);

  // configuration registers, written only while the block is idle: a rule for the user, with no guard in the block
  logic [sgpf_pkg::CFG_W-1:0] gravity;
  logic [sgpf_pkg::CFG_W-1:0] soften;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity <= sgpf_pkg::GRAVITY_RESET;
      soften  <= sgpf_pkg::SOFTEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sgpf_pkg::REG_GRAVITY: gravity <= cfg_data;
        sgpf_pkg::REG_SOFTEN:  soften  <= cfg_data;
        default:               gravity <= gravity;
      endcase
    end
  end

  // front: classify the pair and drop it into the queue
  sgpf_pkg::item_t  q_wdata;
  sgpf_pkg::item_t  q_rdata;
  sgpf_pkg::qstat_t q_stat;
  logic             q_push;
  logic             q_pop;

  sgpf_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .self_x    (self_x),
    .self_y    (self_y),
    .self_mass (self_mass),
    .other_x   (other_x),
    .other_y   (other_y),
    .other_mass(other_mass),
    .qstat     (q_stat),
    .push      (q_push),
    .item      (q_wdata)
  );

  sgpf_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .stat (q_stat)
  );

  // back: the arithmetic pipeline, advanced whenever the output can move
  sgpf_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .gravity   (gravity),
    .soften    (soften),
    .qstat     (q_stat),
    .head      (q_rdata),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .force_x   (force_x),
    .force_y   (force_y),
    .coincident(coincident),
    .saturated (saturated)
  );

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("queue read while empty");

  a_coinc_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && coincident |-> force_x == '0 && force_y == '0 && !saturated)
    else $error("coincident result carries force");

  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      force_x == sgpf_pkg::FORCE_POS_MAX || force_x == sgpf_pkg::FORCE_NEG_MAG ||
      force_y == sgpf_pkg::FORCE_POS_MAX || force_y == sgpf_pkg::FORCE_NEG_MAG)
    else $error("saturated flag without a clamped component");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top: testbench of the softened gravity pair force unit
// Streams body pairs under several G and softening settings and under varied
// sender idling and receiver stalls. Each transfer is predicted with exact
// wide integer arithmetic, and results are checked in order, field by field.
// ============================================================================
module tb_top;

  localparam int SETTLE_CYCLES = 120;   // longer than the pipeline latency
  localparam int FRAC_BITS_TB  = 16;

  typedef struct {
    logic [31:0] sx, sy, sm, ox, oy, om;
  } pair_t;

  typedef struct {
    logic [sgpf_pkg::FORCE_W-1:0] fx, fy;
    logic                         coinc, sat;
  } force_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [sgpf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sgpf_pkg::CFG_W-1:0]     cfg_data  = '0;

  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic signed [sgpf_pkg::COORD_W-1:0] self_x = '0, self_y = '0;
  logic signed [sgpf_pkg::COORD_W-1:0] other_x = '0, other_y = '0;
  logic        [sgpf_pkg::MASS_W-1:0]  self_mass = '0, other_mass = '0;

  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic signed [sgpf_pkg::FORCE_W-1:0] force_x, force_y;
  logic                                coincident, saturated;

  // predictor copy of the two registers
  logic [31:0] grav_now = sgpf_pkg::GRAVITY_RESET;
  logic [31:0] soft_now = sgpf_pkg::SOFTEN_RESET;

  pair_t  pending_pairs[$];
  force_t expected_forces[$];
  int     send_idle_pct = 0;
  int     stall_pct     = 0;
  int     mismatches    = 0;

  softened_gravity_pair_force_unit i_dut (
    .clk, .rst,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .self_x, .self_y, .self_mass,
    .other_x, .other_y, .other_mass,
    .out_valid, .out_stall, .force_x, .force_y, .coincident, .saturated
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  // Integer square root, bit by bit, floor of sqrt(n).
  function automatic logic [63:0] isqrt128(input logic [127:0] n);
    logic [127:0] res, bitv, trial;
    res = '0;
    for (int k = 63; k >= 0; k--) begin
      bitv  = 128'd1 << (2 * k);
      trial = res + bitv;
      if (n >= trial) begin
        n   = n - trial;
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
    end
    return res[63:0];
  endfunction

  // One force component: scale the scalar force by the unit vector, clamp.
  function automatic logic [sgpf_pkg::FORCE_W-1:0] scale_component(
      input logic [127:0] fq, input logic [32:0] mag, input logic neg,
      input logic [63:0] dist_h, inout logic sat);
    logic [127:0] unit_c;
    logic [159:0] prod;
    logic [47:0]  lim, m;
    unit_c = ({95'd0, mag} << sgpf_pkg::U_SHIFT) / {64'd0, dist_h};
    if (unit_c > (128'd1 << sgpf_pkg::UNIT_BITS)) unit_c = 128'd1 << sgpf_pkg::UNIT_BITS;
    prod = ({32'd0, fq} * {32'd0, unit_c}) >> sgpf_pkg::UNIT_BITS;
    lim  = neg ? sgpf_pkg::FORCE_NEG_MAG : sgpf_pkg::FORCE_POS_MAX;
    if (prod > {112'd0, lim}) begin
      m   = lim;
      sat = 1'b1;
    end else begin
      m = prod[47:0];
    end
    return neg ? (48'd0 - m) : m;
  endfunction

  function automatic force_t pair_force(input pair_t p);
    force_t       r;
    logic [32:0]  dx, dy, adx, ady;
    logic [127:0] sq, den, num, fq;
    logic [63:0]  dist_h;
    logic         sat;
    dx  = {p.ox[31], p.ox} - {p.sx[31], p.sx};
    dy  = {p.oy[31], p.oy} - {p.sy[31], p.sy};
    adx = dx[32] ? -dx : dx;
    ady = dy[32] ? -dy : dy;
    sq  = {95'd0, adx} * {95'd0, adx} + {95'd0, ady} * {95'd0, ady};
    r.coinc = 1'b0;
    r.sat   = 1'b0;
    r.fx    = '0;
    r.fy    = '0;
    if (sq == 0) begin
      r.coinc = 1'b1;
      return r;
    end
    den    = sq + ({96'd0, soft_now} << FRAC_BITS_TB);
    num    = ({96'd0, grav_now} * {96'd0, p.sm}) * {96'd0, p.om};
    fq     = num / den;
    dist_h = isqrt128(sq << 32);
    sat    = 1'b0;
    r.fx   = scale_component(fq, adx, dx[32], dist_h, sat);
    r.fy   = scale_component(fq, ady, dy[32], dist_h, sat);
    r.sat  = sat;
    return r;
  endfunction

  function automatic logic [31:0] rand_mass();
    if ($urandom_range(2) == 0) return $urandom;
    return $urandom >> $urandom_range(31);
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int    mode;
    mode = $urandom_range(9);
    p.sx = $urandom;
    p.sy = $urandom;
    p.sm = rand_mass();
    p.om = rand_mass();
    case (mode)
      0, 1: begin
        p.ox = $urandom;
        p.oy = $urandom;
      end
      7: begin
        p.ox = p.sx;
        p.oy = p.sy;
      end
      8: begin
        p.sx = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        p.sy = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        p.ox = ~p.sx;
        p.oy = $urandom_range(1) ? ~p.sy : p.sy;
      end
      9: begin
        p.ox = p.sx + ($urandom >> $urandom_range(31));
        p.oy = p.sy;
      end
      default: begin
        // close pair: small signed offsets, the physically common case
        p.ox = p.sx + (($urandom_range(1) ? -1 : 1) * int'($urandom >> $urandom_range(8, 31)));
        p.oy = p.sy + (($urandom_range(1) ? -1 : 1) * int'($urandom >> $urandom_range(8, 31)));
      end
    endcase
    return p;
  endfunction

  function automatic pair_t mk(input logic [31:0] sx, sy, sm, ox, oy, om);
    pair_t p;
    p.sx = sx; p.sy = sy; p.sm = sm; p.ox = ox; p.oy = oy; p.om = om;
    return p;
  endfunction

  // Sender: advance to the next pair only once the current one is transferred.
  always @(posedge clk) begin : drive_pairs
    pair_t p;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        p = pending_pairs.pop_front();
        in_valid   <= 1'b1;
        self_x     <= p.sx;
        self_y     <= p.sy;
        self_mass  <= p.sm;
        other_x    <= p.ox;
        other_y    <= p.oy;
        other_mass <= p.om;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver backpressure.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Predict each accepted input transfer.
  always @(posedge clk) begin : predict_forces
    pair_t p;
    if (!rst && in_valid && !in_stall) begin
      p = mk(self_x, self_y, self_mass, other_x, other_y, other_mass);
      expected_forces.push_back(pair_force(p));
    end
  end

  // Compare each output transfer with the oldest prediction.
  always @(posedge clk) begin : check_forces
    force_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_forces.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: fx=%h fy=%h coinc=%b sat=%b",
                   force_x, force_y, coincident, saturated);
      end else begin
        e = expected_forces.pop_front();
        if (force_x !== e.fx || force_y !== e.fy || coincident !== e.coinc ||
            saturated !== e.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp fx=%h fy=%h c=%b s=%b  got fx=%h fy=%h c=%b s=%b",
                     e.fx, e.fy, e.coinc, e.sat,
                     force_x, force_y, coincident, saturated);
        end
      end
    end
  end

  // Write one register; only called while the pipeline is empty.
  task automatic write_reg(input sgpf_pkg::cfg_reg_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == sgpf_pkg::REG_GRAVITY) grav_now = val;
    else soft_now = val;
  endtask

  // Hold until every pair is sent and every result has come back, then settle.
  // Check between edges so the sender's updates have landed.
  task automatic drain();
    while (pending_pairs.size() > 0 || in_valid || expected_forces.size() > 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input int n, input int idle, input int stall);
    send_idle_pct = idle;
    stall_pct     = stall;
    repeat (n) pending_pairs.push_back(rand_pair());
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed pairs under reset registers, no idling.
    pending_pairs.push_back(mk(0, 0, 32'h10000, 0, 0, 32'h10000));            // coincident
    pending_pairs.push_back(mk(32'h8000_0000, 32'h8000_0000, '1,
                               32'h8000_0000, 32'h8000_0000, '1));         // coincident at min
    pending_pairs.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, '1,
                               32'h7FFF_FFFF, 32'h7FFF_FFFF, '1));         // coincident at max
    pending_pairs.push_back(mk(32'h8000_0000, 32'h8000_0000, '1,
                               32'h7FFF_FFFF, 32'h7FFF_FFFF, '1));         // widest span
    pending_pairs.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, '1,
                               32'h8000_0000, 32'h8000_0000, '1));         // widest, negative
    pending_pairs.push_back(mk(32'h8000_0000, 32'h7FFF_FFFF, '1,
                               32'h7FFF_FFFF, 32'h8000_0000, '1));
    pending_pairs.push_back(mk(0, 0, '1, 1, 0, '1));                       // saturate +x
    pending_pairs.push_back(mk(0, 0, '1, -1, 0, '1));                      // saturate -x
    pending_pairs.push_back(mk(0, 0, '1, 0, 1, '1));                       // saturate +y
    pending_pairs.push_back(mk(0, 0, '1, 0, -1, '1));                      // saturate -y
    pending_pairs.push_back(mk(0, 0, '1, 1, -1, '1));                      // saturate diagonal
    pending_pairs.push_back(mk(0, 0, 32'h10000, 32'h10000, 0, 32'h10000)); // unit distance
    pending_pairs.push_back(mk(0, 0, 32'h10000, 0, 32'hFFFF_0000, 32'h10000));
    pending_pairs.push_back(mk(0, 0, 32'h10000, 32'h30000, 32'h40000, 32'h10000)); // 3-4-5
    pending_pairs.push_back(mk(0, 0, 0, 32'h10000, 32'h10000, '1));        // zero mass
    pending_pairs.push_back(mk(0, 0, '1, 32'h10000, 32'h10000, 0));
    pending_pairs.push_back(mk(32'h8000_0000, 0, 1, 32'h7FFF_FFFF, 0, 1)); // truncates to zero
    pending_pairs.push_back(mk(0, 32'h8000_0000, 1, 0, 32'h7FFF_FFFF, 1));
    pending_pairs.push_back(mk(5, -7, 32'h2_0000, -3, 11, 32'h8000));
    pending_pairs.push_back(mk(32'h1234_5678, 32'h8765_4321, 32'hDEAD_BEEF,
                               32'h1234_5679, 32'h8765_4320, 32'hCAFE_F00D));
    drain();

    // Random phases across register settings and handshake pressure.
    random_phase(100, 0, 0);
    write_reg(sgpf_pkg::REG_GRAVITY, 32'd0);
    write_reg(sgpf_pkg::REG_SOFTEN, 32'd0);
    random_phase(60, 80, 0);
    write_reg(sgpf_pkg::REG_GRAVITY, 32'hFFFF_FFFF);
    write_reg(sgpf_pkg::REG_SOFTEN, 32'hFFFF_FFFF);
    random_phase(100, 0, 80);
    write_reg(sgpf_pkg::REG_GRAVITY, $urandom);
    write_reg(sgpf_pkg::REG_SOFTEN, $urandom >> $urandom_range(31));
    random_phase(100, 29, 29);
    write_reg(sgpf_pkg::REG_GRAVITY, 32'h0001_0000);
    write_reg(sgpf_pkg::REG_SOFTEN, 32'd0);
    random_phase(120, 0, 0);
    write_reg(sgpf_pkg::REG_GRAVITY, $urandom);
    write_reg(sgpf_pkg::REG_SOFTEN, 32'd1);
    random_phase(150, 29, 29);
    send_idle_pct = 0;
    stall_pct     = 0;

    if (mismatches == 0 && expected_forces.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
